[hw/rtl/bcho_pkg.sv]
package bcho_pkg;

    // Item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // Type codes
    localparam logic [8:0] TYPE_COMPARE = 9'h100;
    localparam logic [8:0] TYPE_PLAIN_A = 9'h000;
    localparam logic [8:0] TYPE_PLAIN_B = 9'h001;
    localparam logic [8:0] TYPE_PLAIN_C = 9'h080;
    localparam logic [8:0] TYPE_BANK_LO = 9'h090;
    localparam logic [8:0] TYPE_BANK_HI = 9'h097;

    // Banked work RAM window, [lo, hi)
    localparam logic [15:0] BANK_WIN_LO = 16'hD000;
    localparam logic [15:0] BANK_WIN_HI = 16'hE000;

    // Stored entry body; the enable lives in flip-flops beside the memory
    typedef struct packed {
        logic [8:0]  etype;
        logic [15:0] addr;
        logic [7:0]  value;
        logic [7:0]  compare;
    } t_entry;

    // Rule check of one entry against a read (address match done by caller)
    function automatic logic entry_fires(input t_entry e, input logic [15:0] addr,
                                         input logic [7:0] orig, input logic [2:0] bank);
        logic f;
        f = 1'b0;
        if (e.etype == TYPE_COMPARE) begin
            f = (orig == e.compare);
        end else if (e.etype == TYPE_PLAIN_A || e.etype == TYPE_PLAIN_B ||
                     e.etype == TYPE_PLAIN_C) begin
            f = 1'b1;
        end else if (e.etype >= TYPE_BANK_LO && e.etype <= TYPE_BANK_HI) begin
            if (addr >= BANK_WIN_LO && addr < BANK_WIN_HI) begin
                f = (bank == 3'(e.etype - TYPE_BANK_LO));
            end else begin
                f = 1'b1;
            end
        end
        return f;
    endfunction

endpackage

[hw/rtl/bcho_table.sv]
module bcho_table #(
    parameter int ENTRIES = 128,
    parameter int IDX_W   = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [IDX_W-1:0]     i_waddr,
    input  logic                 i_wen_bit,
    input  bcho_pkg::t_entry     i_wdata,
    input  logic [IDX_W-1:0]     i_raddr,
    output bcho_pkg::t_entry     o_rdata,
    output logic                 o_rvld
);

    bcho_pkg::t_entry r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_vld;

    // Entry bodies: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

    // Enable bits, cleared by reset so unwritten entries never fire
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            o_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= i_wen_bit;
            end
            o_rvld <= r_vld[i_raddr];
        end
    end

endmodule

[hw/rtl/bus_read_cheat_override.sv]
// Channel   | Dir | Handshake                  | Beat contents
// ----------+-----+----------------------------+----------------------------------------
// command   | in  | i_start & !o_busy          | i_kind, i_slot, i_entry_*, i_address,
//           |     |                            | i_original_data, i_wram_bank
// result    | out | o_strobe (one cycle)       | o_read_data, o_patched
//
// An entry write gives no result; o_busy stays low.
// A read walks the table one slot per cycle through the memory read port:
// each slot's data is registered, then a hit or the last slot's miss registers o_strobe.
// o_busy is high for the whole walk; the next beat can go at the edge ending the strobe.
// Reset (synchronous, active low) clears every enable bit at once: no sweep.
// The receiver cannot stall; each result is shown for exactly one cycle.
module bus_read_cheat_override #(
    parameter int ENTRIES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_kind,
    input  logic [6:0]  i_slot,
    input  logic        i_entry_enabled,
    input  logic [8:0]  i_entry_type,
    input  logic [7:0]  i_entry_value,
    input  logic [7:0]  i_entry_compare,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_original_data,
    input  logic [2:0]  i_wram_bank,
    output logic        o_strobe,
    output logic [7:0]  o_read_data,
    output logic        o_patched
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SLOT_W = (IDX_W > 7) ? IDX_W : 7;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic             r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_issue_done, n_issue_done;   // last slot already requested
    logic             r_pend, n_pend;               // memory data valid this cycle
    logic             r_pend_last, n_pend_last;     // that data is the last slot
    logic [15:0]      r_addr;
    logic [7:0]       r_orig;
    logic [2:0]       r_bank;
    logic             r_strobe, n_strobe;
    logic [7:0]       r_data, n_data;
    logic             r_patched, n_patched;

    logic             take;
    logic             wr_en;
    logic [SLOT_W-1:0] slot_ext;
    bcho_pkg::t_entry wdata;
    bcho_pkg::t_entry rdata;
    logic             rvld;
    logic             hit;

    assign take     = i_start && (r_state == S_IDLE);
    assign slot_ext = SLOT_W'(i_slot);
    // writes beyond the table are dropped
    assign wr_en    = take && (i_kind == bcho_pkg::KIND_WRITE) &&
                      ({2'b00, i_slot} < 9'(ENTRIES));

    assign wdata.etype   = i_entry_type;
    assign wdata.addr    = i_address;
    assign wdata.value   = i_entry_value;
    assign wdata.compare = i_entry_compare;

    bcho_table #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (wr_en),
        .i_waddr   (slot_ext[IDX_W-1:0]),
        .i_wen_bit (i_entry_enabled),
        .i_wdata   (wdata),
        .i_raddr   (r_idx),
        .o_rdata   (rdata),
        .o_rvld    (rvld)
    );

    // First enabled entry at the read address whose rule fires wins
    assign hit = r_pend && rvld && (rdata.addr == r_addr) &&
                 bcho_pkg::entry_fires(rdata, r_addr, r_orig, r_bank);

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_issue_done = r_issue_done;
        n_pend       = 1'b0;
        n_pend_last  = r_pend_last;
        n_strobe     = 1'b0;
        n_data       = r_data;
        n_patched    = r_patched;
        unique case (r_state)
            S_IDLE: begin
                if (take && (i_kind == bcho_pkg::KIND_READ)) begin
                    n_state      = S_RUN;
                    n_idx        = '0;
                    n_issue_done = 1'b0;
                end
            end
            S_RUN: begin
                // request the slot at r_idx; data comes back next cycle
                if (!r_issue_done) begin
                    n_pend      = 1'b1;
                    n_pend_last = (r_idx == LAST_IDX);
                    if (r_idx == LAST_IDX) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                if (hit || (r_pend && r_pend_last)) begin
                    n_state   = S_IDLE;
                    n_pend    = 1'b0;
                    n_strobe  = 1'b1;
                    n_data    = hit ? rdata.value : r_orig;
                    n_patched = hit;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_issue_done <= 1'b0;
            r_pend       <= 1'b0;
            r_pend_last  <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_issue_done <= n_issue_done;
            r_pend       <= n_pend;
            r_pend_last  <= n_pend_last;
            r_strobe     <= n_strobe;
        end
    end

    // Payload registers: read context and result beat
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_addr <= i_address;
            r_orig <= i_original_data;
            r_bank <= i_wram_bank;
        end
        r_data    <= n_data;
        r_patched <= n_patched;
    end

    assign o_busy      = (r_state == S_RUN);
    assign o_strobe    = r_strobe;
    assign o_read_data = r_data;
    assign o_patched   = r_patched;

endmodule

[dv/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES = 128;

    // One command beat as the driver presents it
    typedef struct {
        logic        kind;
        logic [6:0]  slot;
        logic        en;
        logic [8:0]  etype;
        logic [7:0]  value;
        logic [7:0]  cmp;
        logic [15:0] addr;
        logic [7:0]  orig;
        logic [2:0]  bank;
    } t_bus_cmd;

    // What the CPU should see for one read
    typedef struct {
        logic [7:0] data;
        logic       patched;
    } t_cpu_byte;

    // ------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        i_kind = 1'b0;
    logic [6:0]  i_slot = '0;
    logic        i_entry_enabled = 1'b0;
    logic [8:0]  i_entry_type = '0;
    logic [7:0]  i_entry_value = '0;
    logic [7:0]  i_entry_compare = '0;
    logic [15:0] i_address = '0;
    logic [7:0]  i_original_data = '0;
    logic [2:0]  i_wram_bank = '0;
    logic        o_busy;
    logic        o_strobe;
    logic [7:0]  o_read_data;
    logic        o_patched;

    bus_read_cheat_override #(
        .ENTRIES(ENTRIES)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_kind          (i_kind),
        .i_slot          (i_slot),
        .i_entry_enabled (i_entry_enabled),
        .i_entry_type    (i_entry_type),
        .i_entry_value   (i_entry_value),
        .i_entry_compare (i_entry_compare),
        .i_address       (i_address),
        .i_original_data (i_original_data),
        .i_wram_bank     (i_wram_bank),
        .o_strobe        (o_strobe),
        .o_read_data     (o_read_data),
        .o_patched       (o_patched)
    );

    // 8 ns clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Reset held low from the start, then released once
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the patch table and the read-path predictor
    // ------------------------------------------------------------------
    logic             shadow_en  [ENTRIES];
    bcho_pkg::t_entry shadow_tbl [ENTRIES];

    t_bus_cmd  pending_cmds[$];    // beats not yet presented
    t_cpu_byte expected_bytes[$];  // reads taken, result not yet seen
    int        n_errors = 0;

    initial begin
        for (int s = 0; s < ENTRIES; s++) begin
            shadow_en[s]  = 1'b0;
            shadow_tbl[s] = '0;
        end
    end

    // Does one stored entry supply the byte for this read? (address already matched)
    function automatic logic rule_fires(bcho_pkg::t_entry e, logic [15:0] a,
                                        logic [7:0] orig, logic [2:0] bank);
        logic in_window;
        in_window = (a >= bcho_pkg::BANK_WIN_LO) && (a < bcho_pkg::BANK_WIN_HI);
        case (e.etype)
            bcho_pkg::TYPE_COMPARE: return orig == e.compare;
            bcho_pkg::TYPE_PLAIN_A, bcho_pkg::TYPE_PLAIN_B,
            bcho_pkg::TYPE_PLAIN_C: return 1'b1;
            default: begin
                // banked codes carry the bank number in their low three bits
                if (e.etype >= bcho_pkg::TYPE_BANK_LO && e.etype <= bcho_pkg::TYPE_BANK_HI)
                    return !in_window || (e.etype[2:0] == bank);
                return 1'b0;    // unknown code never fires
            end
        endcase
    endfunction

    // Priority walk: lowest enabled slot at this address whose rule fires wins;
    // a matching entry that does not fire just lets the walk go on.
    function automatic t_cpu_byte predict_read(t_bus_cmd c);
        t_cpu_byte r;
        r.data    = c.orig;
        r.patched = 1'b0;
        for (int s = 0; s < ENTRIES; s++) begin
            if (shadow_en[s] && shadow_tbl[s].addr == c.addr &&
                rule_fires(shadow_tbl[s], c.addr, c.orig, c.bank)) begin
                r.data    = shadow_tbl[s].value;
                r.patched = 1'b1;
                return r;
            end
        end
        return r;
    endfunction

    // Called at the edge that takes a beat
    task automatic take_beat(t_bus_cmd c);
        if (c.kind == bcho_pkg::KIND_WRITE) begin
            // slot is 7 bits wide, so it always lands inside a 128-entry table
            if (int'(c.slot) < ENTRIES) begin
                shadow_en[c.slot]          = c.en;
                shadow_tbl[c.slot].etype   = c.etype;
                shadow_tbl[c.slot].addr    = c.addr;
                shadow_tbl[c.slot].value   = c.value;
                shadow_tbl[c.slot].compare = c.cmp;
            end
        end else begin
            expected_bytes.push_back(predict_read(c));
        end
    endtask

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        n_errors++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers; fields a beat does not use carry random junk
    // ------------------------------------------------------------------
    task automatic push_write(int slot, logic en, logic [8:0] etype, logic [7:0] value,
                              logic [7:0] cmp, logic [15:0] addr);
        t_bus_cmd c;
        c.kind  = bcho_pkg::KIND_WRITE;
        c.slot  = 7'(slot);
        c.en    = en;
        c.etype = etype;
        c.value = value;
        c.cmp   = cmp;
        c.addr  = addr;
        c.orig  = 8'($urandom);
        c.bank  = 3'($urandom);
        pending_cmds.push_back(c);
    endtask

    task automatic push_read(logic [15:0] addr, logic [7:0] orig, logic [2:0] bank);
        t_bus_cmd c;
        c.kind  = bcho_pkg::KIND_READ;
        c.slot  = 7'($urandom);
        c.en    = 1'($urandom);
        c.etype = 9'($urandom);
        c.value = 8'($urandom);
        c.cmp   = 8'($urandom);
        c.addr  = addr;
        c.orig  = orig;
        c.bank  = bank;
        pending_cmds.push_back(c);
    endtask

    // Small address pool so reads actually hit entries; includes the bank
    // window edges on both sides.
    function automatic logic [15:0] pick_addr();
        logic [15:0] pool [10];
        pool = '{16'h0000, 16'hFFFF, 16'hCFFF, 16'hD000, 16'hD7A5,
                 16'hDFFF, 16'hE000, 16'h4000, 16'hFF80, 16'h0150};
        if ($urandom_range(0, 99) < 80)
            return pool[$urandom_range(0, 9)];
        return 16'($urandom);
    endfunction

    function automatic logic [7:0] pick_byte();
        logic [7:0] pool [4];
        pool = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
        if ($urandom_range(0, 1) == 0)
            return pool[$urandom_range(0, 3)];
        return 8'($urandom);
    endfunction

    function automatic logic [8:0] pick_type();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1:    return bcho_pkg::TYPE_COMPARE;
            2:       return bcho_pkg::TYPE_PLAIN_A;
            3:       return bcho_pkg::TYPE_PLAIN_B;
            4:       return bcho_pkg::TYPE_PLAIN_C;
            5, 6, 7: return bcho_pkg::TYPE_BANK_LO + 9'($urandom_range(0, 7));
            default: return 9'($urandom);    // mostly unknown codes
        endcase
    endfunction

    // Idle cycles before the next beat: mostly none or short, a few long,
    // with stretches of back-to-back beats.
    int calm_left = 0;

    function automatic int draw_gap();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 99) < 3) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 100);
    endfunction

    // ------------------------------------------------------------------
    // Driver: a beat is taken at an edge with start high and busy low.
    // Fields stay put while start waits on busy.
    // ------------------------------------------------------------------
    t_bus_cmd cur_cmd;
    int       hold_cnt = 0;
    logic     port_free;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
            hold_cnt = 0;
        end else begin
            port_free = !i_start || !o_busy;
            if (i_start && !o_busy) begin
                take_beat(cur_cmd);
                hold_cnt = draw_gap();
            end
            if (port_free) begin
                if (hold_cnt == 0 && pending_cmds.size() > 0) begin
                    cur_cmd = pending_cmds.pop_front();
                    i_kind          <= cur_cmd.kind;
                    i_slot          <= cur_cmd.slot;
                    i_entry_enabled <= cur_cmd.en;
                    i_entry_type    <= cur_cmd.etype;
                    i_entry_value   <= cur_cmd.value;
                    i_entry_compare <= cur_cmd.cmp;
                    i_address       <= cur_cmd.addr;
                    i_original_data <= cur_cmd.orig;
                    i_wram_bank     <= cur_cmd.bank;
                    i_start         <= 1'b1;
                end else begin
                    if (hold_cnt > 0)
                        hold_cnt--;
                    i_start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every strobe is one result beat, checked against the oldest read
    // ------------------------------------------------------------------
    t_cpu_byte want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("result with no read pending: data=%02h patched=%b",
                                          o_read_data, o_patched));
            end else begin
                want = expected_bytes.pop_front();
                if (o_read_data !== want.data)
                    report_mismatch($sformatf("read_data %02h, want %02h",
                                              o_read_data, want.data));
                if (o_patched !== want.patched)
                    report_mismatch($sformatf("patched %b, want %b",
                                              o_patched, want.patched));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        logic [15:0] last_wr_addr;
        logic [15:0] a;
        int          slot;

        last_wr_addr = 16'h4000;

        // --- directed ---
        push_read(16'h0000, 8'hFF, 3'd0);                       // empty table: pass-through
        push_write(0, 1'b1, bcho_pkg::TYPE_PLAIN_A, 8'h00, 8'h00, 16'hFFFF);
        push_read(16'hFFFF, 8'hFF, 3'd7);                       // plain code fires
        push_write(127, 1'b1, bcho_pkg::TYPE_COMPARE, 8'hAA, 8'h55, 16'h1234);
        push_read(16'h1234, 8'h55, 3'd1);                       // compare hit in last slot
        push_read(16'h1234, 8'h54, 3'd1);                       // compare miss
        push_write(5, 1'b1, bcho_pkg::TYPE_BANK_LO + 9'd3, 8'h11, 8'h00, 16'hD000);
        push_read(16'hD000, 8'h01, 3'd3);                       // bank match at window start
        push_read(16'hD000, 8'h01, 3'd2);                       // bank mismatch
        push_write(6, 1'b1, bcho_pkg::TYPE_BANK_HI, 8'h22, 8'h00, 16'hCFFF);
        push_read(16'hCFFF, 8'h02, 3'd0);                       // banked below window: always
        push_write(7, 1'b1, bcho_pkg::TYPE_BANK_LO, 8'h33, 8'h00, 16'hDFFF);
        push_read(16'hDFFF, 8'h03, 3'd0);                       // last window byte, bank 0
        push_read(16'hDFFF, 8'h03, 3'd7);
        push_write(8, 1'b1, bcho_pkg::TYPE_BANK_HI, 8'h44, 8'h00, 16'hE000);
        push_read(16'hE000, 8'h04, 3'd0);                       // window end is exclusive
        // compare miss in slot 3 falls through to plain entry in slot 4
        push_write(3, 1'b1, bcho_pkg::TYPE_COMPARE, 8'h10, 8'h01, 16'h4000);
        push_write(4, 1'b1, bcho_pkg::TYPE_PLAIN_C, 8'h20, 8'h00, 16'h4000);
        push_write(1, 1'b1, 9'h1FF, 8'h77, 8'h01, 16'h4000);    // unknown code, passed over
        push_write(2, 1'b0, bcho_pkg::TYPE_PLAIN_B, 8'h66, 8'h01, 16'h4000); // disabled
        push_read(16'h4000, 8'h01, 3'd5);
        push_read(16'h4000, 8'h02, 3'd5);
        push_write(9, 1'b1, bcho_pkg::TYPE_PLAIN_B, 8'h99, 8'h00, 16'hFFFF); // loses to slot 0
        push_read(16'hFFFF, 8'h00, 3'd4);

        // --- random ---
        for (int n = 0; n < 1560; n++) begin
            // two full wipes so the table does not fill up with winners
            if (n == 520 || n == 1040) begin
                for (int s = 0; s < ENTRIES; s++)
                    push_write(s, 1'b0, 9'($urandom), 8'($urandom), 8'($urandom),
                               16'($urandom));
            end
            if ($urandom_range(0, 99) < 35) begin
                slot = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15)
                                                   : $urandom_range(0, 127);
                a = pick_addr();
                last_wr_addr = a;
                push_write(slot, $urandom_range(0, 99) < 85, pick_type(), 8'($urandom),
                           pick_byte(), a);
            end else begin
                a = ($urandom_range(0, 1) == 0) ? last_wr_addr : pick_addr();
                push_read(a, pick_byte(), 3'($urandom));
            end
        end

        // wait for the last beat to be taken and its result to show
        @(posedge i_clk);
        while (pending_cmds.size() != 0 || i_start || expected_bytes.size() != 0)
            @(posedge i_clk);
        // catch any stray strobe after the last read
        repeat (ENTRIES + 4) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #(16_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule
